// ===== hw/rtl/frequency_occupancy_cell_map_defines.svh =====
// Assertion macros shared by the cell map RTL.
`ifndef FREQUENCY_OCCUPANCY_CELL_MAP_DEFINES_SVH
`define FREQUENCY_OCCUPANCY_CELL_MAP_DEFINES_SVH

// Same-cycle implication, checked on i_clk with i_rst_n low as the disable.
`define FOCCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FOCCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/foccm_pkg.sv =====
// Types and constants of the occupancy cell map.
`timescale 1ns / 1ps
`default_nettype none

package foccm_pkg;

    localparam int AXIS_BITS    = 5;
    localparam int COUNT_BITS   = 16;
    localparam int ADDR_BITS    = 3 * AXIS_BITS;
    localparam int CELL_COUNT   = 1 << ADDR_BITS;
    localparam int MEM_W        = 2 * COUNT_BITS;
    localparam int FRAC_BITS    = 16;
    localparam int PROB_BITS    = FRAC_BITS + 1;
    localparam int THR_BITS     = 17;
    localparam int PROD_BITS    = THR_BITS + COUNT_BITS;
    localparam int DIV_CNT_BITS = $clog2(PROB_BITS);

    localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(16384);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] FUNC_QUERY   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_OCC     = 2'd2;
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_FREE = 2'd1;
    localparam logic [1:0] CLS_OCC  = 2'd2;

    typedef struct packed {
        logic                 re;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [MEM_W-1:0]     wdata;   // {visited, occupied}
    } t_mem_req;

    typedef struct packed {
        logic                 done;
        logic [PROB_BITS-1:0] quot;
        logic                 rem_nz;
    } t_div_res;

endpackage

`default_nettype wire

// ===== hw/rtl/frequency_occupancy_cell_map.sv =====
// Top level of the occupancy cell map: sequencer, threshold register and result register.
//
// Usage:
//   Commands enter on start with i_func and i_cell_x/y/z; a command is taken at a
//   clock edge where start is high and busy is low. Exactly one result follows per
//   command on the o_ ports, marked by o_strobe for a single cycle.
//   The receiver cannot stall; every strobe must be captured when it appears.
//   Each command reads the cell, multiplies the threshold by the old visited count
//   to classify the cell before the update, writes the updated counts, and then
//   runs a bit-serial divider for occupied/visited (one quotient bit per cycle).
//   Busy drops in the same cycle as the result strobe, so a new command is not
//   taken until the previous result strobes. A cell whose visited count ends at
//   zero skips the divider; its result is registered from the update state.
//   After reset the count memory is swept to zero, one cell per cycle, over all
//   32768 cells; busy is high throughout. Threshold writes through
//   i_cfg_we/i_cfg_wdata are taken at any time and should only be made between
//   commands. Reset sets the threshold to 0.25 (16384 in Q1.16).
`timescale 1ns / 1ps
`default_nettype none

`include "frequency_occupancy_cell_map_defines.svh"

module frequency_occupancy_cell_map
    import foccm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [THR_BITS-1:0]  i_cfg_wdata,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [4:0]           i_cell_x,
    input  wire logic [4:0]           i_cell_y,
    input  wire logic [4:0]           i_cell_z,
    output logic                      o_strobe,
    output logic                      o_changed,
    output logic                      o_is_free,
    output logic                      o_is_occupied,
    output logic                      o_is_unknown,
    output logic [PROB_BITS-1:0]      o_probability,
    output logic                      o_saturated
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [THR_BITS-1:0]   r_thr;
    logic [1:0]            r_func;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [COUNT_BITS-1:0] r_occ;
    logic [COUNT_BITS-1:0] r_vis;
    logic [PROD_BITS-1:0]  r_prod;
    logic [1:0]            r_before;
    logic                  r_sat;

    logic                  r_out_valid;
    logic                  r_out_changed;
    logic                  r_out_free;
    logic                  r_out_occ;
    logic                  r_out_unknown;
    logic [PROB_BITS-1:0]  r_out_prob;
    logic                  r_out_sat;

    t_mem_req              mem_req;
    logic [MEM_W-1:0]      mem_rdata;
    logic                  mem_clearing;
    t_div_res              div_res;

    logic                  accept;
    logic [ADDR_BITS-1:0]  in_addr;
    logic                  is_mark;
    logic                  upd_sat;
    logic [COUNT_BITS-1:0] new_occ;
    logic [COUNT_BITS-1:0] new_vis;
    logic [PROD_BITS-1:0]  lhs;
    logic [1:0]            before_cls;
    logic                  aft_free;
    logic                  aft_occ;
    logic                  div_changed;

    assign busy    = !i_rst_n || (r_state != S_IDLE) || mem_clearing;
    assign accept  = start && !busy;
    assign in_addr = {ADDR_BITS'(i_cell_z[AXIS_BITS-1:0]) << (2 * AXIS_BITS)}
                   | {ADDR_BITS'(i_cell_y[AXIS_BITS-1:0]) << AXIS_BITS}
                   | ADDR_BITS'(i_cell_x[AXIS_BITS-1:0]);

    // Update stage: class before the step from the registered product, new counts.
    always_comb begin
        is_mark = (r_func == FUNC_FREE) || (r_func == FUNC_OCC);
        upd_sat = is_mark && (r_vis == COUNT_MAX);
        lhs     = PROD_BITS'({r_occ, {FRAC_BITS{1'b0}}});
        if (r_vis == '0) begin
            before_cls = CLS_NONE;
        end else if (lhs < r_prod) begin
            before_cls = CLS_FREE;
        end else if (lhs > r_prod) begin
            before_cls = CLS_OCC;
        end else begin
            before_cls = CLS_NONE;
        end
        if (r_func == FUNC_UNKNOWN) begin
            new_occ = '0;
            new_vis = '0;
        end else if (is_mark && !upd_sat) begin
            new_vis = r_vis + 1'b1;
            new_occ = (r_func == FUNC_OCC) ? (r_occ + 1'b1) : r_occ;
        end else begin
            new_vis = r_vis;
            new_occ = r_occ;
        end
    end

    // With q = floor(occ*2^16/vis) and remainder r, occ*2^16 < thr*vis exactly when
    // q < thr, and occ*2^16 > thr*vis when q > thr or q equals thr with r nonzero.
    always_comb begin
        aft_free = (PROB_BITS'(div_res.quot) < r_thr);
        aft_occ  = (div_res.quot > r_thr) || ((div_res.quot == r_thr) && div_res.rem_nz);
        case (r_func)
            FUNC_FREE: div_changed = !r_sat && (r_before != CLS_FREE) && aft_free;
            FUNC_OCC:  div_changed = !r_sat && (r_before != CLS_OCC) && aft_occ;
            default:   div_changed = 1'b0;
        endcase
    end

    always_comb begin
        mem_req.re    = accept;
        mem_req.we    = (r_state == S_UPD) && ((r_func == FUNC_UNKNOWN) || (is_mark && !upd_sat));
        mem_req.addr  = (r_state == S_IDLE) ? in_addr : r_addr;
        mem_req.wdata = {new_vis, new_occ};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = accept ? S_READ : S_IDLE;
            S_READ:  n_state = S_UPD;
            S_UPD:   n_state = (new_vis == '0) ? S_IDLE : S_DIV;
            S_DIV:   n_state = div_res.done ? S_IDLE : S_DIV;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= ((r_state == S_UPD) && (new_vis == '0))
                        || ((r_state == S_DIV) && div_res.done);
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_addr <= in_addr;
        end
        if (r_state == S_READ) begin
            r_occ  <= mem_rdata[COUNT_BITS-1:0];
            r_vis  <= mem_rdata[MEM_W-1:COUNT_BITS];
            r_prod <= PROD_BITS'(r_thr) * PROD_BITS'(mem_rdata[MEM_W-1:COUNT_BITS]);
        end
        if (r_state == S_UPD) begin
            r_before <= before_cls;
            r_sat    <= upd_sat;
            if (new_vis == '0) begin
                // Unvisited after the step: no division, the threshold stands in.
                r_out_changed <= (r_func == FUNC_UNKNOWN) && (r_vis != '0);
                r_out_free    <= 1'b0;
                r_out_occ     <= 1'b0;
                r_out_unknown <= 1'b1;
                r_out_prob    <= r_thr;
                r_out_sat     <= upd_sat;
            end
        end
        if ((r_state == S_DIV) && div_res.done) begin
            r_out_changed <= div_changed;
            r_out_free    <= aft_free;
            r_out_occ     <= aft_occ;
            r_out_unknown <= 1'b0;
            r_out_prob    <= div_res.quot;
            r_out_sat     <= r_sat;
        end
    end

    foccm_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rdata    (mem_rdata),
        .o_clearing (mem_clearing)
    );

    foccm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_UPD) && (new_vis != '0)),
        .i_num   (new_occ),
        .i_den   (new_vis),
        .o_res   (div_res)
    );

    assign o_strobe      = r_out_valid;
    assign o_changed     = r_out_changed;
    assign o_is_free     = r_out_free;
    assign o_is_occupied = r_out_occ;
    assign o_is_unknown  = r_out_unknown;
    assign o_probability = r_out_prob;
    assign o_saturated   = r_out_sat;

    `FOCCM_ASSERT_NOW(a_top_class_excl, r_out_valid, !(r_out_free && r_out_occ),
        "result is both free and occupied")
    `FOCCM_ASSERT_NOW(a_top_sat_nochg, r_out_valid && r_out_sat, !r_out_changed,
        "refused update reports a change")
    `FOCCM_ASSERT_NEXT(a_top_accept_busy, accept, busy,
        "block not busy after taking an item")
    `FOCCM_ASSERT_NOW(a_top_strobe_src, r_out_valid,
        $past(r_state) == S_UPD || $past(r_state) == S_DIV,
        "result strobe without a finishing item")

endmodule

`default_nettype wire

// ===== hw/rtl/foccm_mem.sv =====
// Cell count memory with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module foccm_mem
    import foccm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mem_req         i_req,
    output logic [MEM_W-1:0]      o_rdata,
    output logic                  o_clearing
);

    logic [MEM_W-1:0]     r_mem [CELL_COUNT];
    logic [MEM_W-1:0]     r_rdata;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ADDR_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ===== hw/rtl/foccm_div.sv =====
// Restoring divider producing occupied/visited in Q1.16, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "frequency_occupancy_cell_map_defines.svh"

module foccm_div
    import foccm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COUNT_BITS-1:0] i_num,
    input  wire logic [COUNT_BITS-1:0] i_den,
    output t_div_res                   o_res
);

    localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(PROB_BITS - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS:0]     r_rem;
    logic [COUNT_BITS-1:0]   r_den;
    logic [PROB_BITS-1:0]    r_quot;

    logic [COUNT_BITS:0] trial;
    logic [COUNT_BITS:0] den_ext;
    logic                qbit;

    // The first step compares the numerator itself, giving the integer bit;
    // the numerator never exceeds the denominator, so one integer bit is enough.
    always_comb begin
        den_ext = {1'b0, r_den};
        trial   = (r_cnt == '0) ? r_rem : {r_rem[COUNT_BITS-1:0], 1'b0};
        qbit    = (trial >= den_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= qbit ? (trial - den_ext) : trial;
            r_quot <= {r_quot[PROB_BITS-2:0], qbit};
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_quot;
    assign o_res.rem_nz = |r_rem;

    `FOCCM_ASSERT_NOW(a_div_no_restart, i_start, !r_busy, "divider restarted while busy")
    `FOCCM_ASSERT_NOW(a_div_done_idle, r_done, !r_busy, "divider done while still busy")
    `FOCCM_ASSERT_NOW(a_div_rem_bound, r_busy, r_rem <= den_ext,
        "divider remainder exceeds denominator")

endmodule

`default_nettype wire
